// File: sv/qsr_pkg.sv
package qsr_pkg;

  localparam int unsigned WORD_BITS_DEF     = 32;
  localparam int unsigned FRACTION_BITS_DEF = 28;
  // Extra integer bits held by the intermediate product q*v.
  localparam int unsigned GUARD_BITS        = 4;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_Z = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_W = 2'd3;

  // Component order is x, y, z, w. Product k = 4*c + j is term j of component c
  // of the Hamilton product l*r.
  localparam logic [1:0] LEFT_IDX [16] = '{
    2'd1, 2'd2, 2'd0, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd2
  };
  localparam logic [1:0] RIGHT_IDX [16] = '{
    2'd2, 2'd1, 2'd3, 2'd0,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd0, 2'd1, 2'd2
  };

  // Terms that are subtracted. The second mask folds the conjugate of q
  // into the signs, so both passes multiply by q itself.
  localparam logic [15:0] NEG_Q_TIMES_V    = 16'hE222;
  localparam logic [15:0] NEG_T_TIMES_CONJ = 16'h0999;

  typedef struct packed {
    logic valid;
    logic sat;
  } ctl_t;

endpackage

// File: sv/qsr_vec_if.sv
interface qsr_vec_if #(
  parameter int unsigned WORD_BITS = qsr_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] vec_x;
  logic signed [WORD_BITS-1:0] vec_y;
  logic signed [WORD_BITS-1:0] vec_z;
  logic signed [WORD_BITS-1:0] vec_w;

  modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

// File: sv/qsr_rot_if.sv
interface qsr_rot_if #(
  parameter int unsigned WORD_BITS = qsr_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] rot_x;
  logic signed [WORD_BITS-1:0] rot_y;
  logic signed [WORD_BITS-1:0] rot_z;
  logic signed [WORD_BITS-1:0] rot_w;
  logic                        saturated;

  modport source (output valid, rot_x, rot_y, rot_z, rot_w, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, rot_w, saturated, output ready);
endinterface

// File: sv/quaternion_sandwich_rotation_core.sv
// Each accepted beat passes mul1, sum1, rnd1, mul2, sum2 and rnd2 in order.
// Throughput: one beat per cycle while rot.ready is high; each of the six stages
// holds an item; a bubble anywhere admits a new beat even while the output stalls.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// quaternion registers with the identity: x, y and z zero, w one.
module quaternion_sandwich_rotation_core #(
  parameter int unsigned WORD_BITS     = qsr_pkg::WORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = qsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [qsr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [WORD_BITS-1:0]                 cfg_wdata,
  qsr_vec_if.sink                              vec,
  qsr_rot_if.source                            rot
);

  // The intermediate product t = q*v keeps four extra integer bits.
  localparam int unsigned TW   = WORD_BITS + qsr_pkg::GUARD_BITS;
  // First pass: q (WORD_BITS) times v (WORD_BITS).
  localparam int unsigned PW1  = 2 * WORD_BITS;
  localparam int unsigned SW1  = PW1 + 3;
  // Second pass: t (TW) times q (WORD_BITS).
  localparam int unsigned PW2  = TW + WORD_BITS;
  localparam int unsigned SW2  = PW2 + 3;

  // Quaternion registers. The user must change configuration only while the pipeline
  // is empty; the block does not enforce it, and every stage reads them directly.
  logic signed [WORD_BITS-1:0] quat [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0] <= '0;
      quat[1] <= '0;
      quat[2] <= '0;
      quat[3] <= WORD_BITS'(1) << FRACTION_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        qsr_pkg::REG_QUAT_X: quat[0] <= cfg_wdata;
        qsr_pkg::REG_QUAT_Y: quat[1] <= cfg_wdata;
        qsr_pkg::REG_QUAT_Z: quat[2] <= cfg_wdata;
        qsr_pkg::REG_QUAT_W: quat[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage controls: each stage holds its own valid bit and the running
  // saturation flag; ready runs backwards so that a stage advances whenever
  // it is empty or its successor advances.
  qsr_pkg::ctl_t in_ctl, mul1_ctl, sum1_ctl, rnd1_ctl, mul2_ctl, sum2_ctl, rnd2_ctl;
  logic          mul1_ready, sum1_ready, rnd1_ready, mul2_ready, sum2_ready, rnd2_ready;

  logic signed [WORD_BITS-1:0] vin  [4];
  logic signed [PW1-1:0]       prod1 [16];
  logic signed [SW1-1:0]       sum1  [4];
  logic signed [TW-1:0]        tq    [4];
  logic signed [PW2-1:0]       prod2 [16];
  logic signed [SW2-1:0]       sum2  [4];
  logic signed [WORD_BITS-1:0] res   [4];

  assign in_ctl.valid = vec.valid;
  assign in_ctl.sat   = 1'b0;
  assign vec.ready    = mul1_ready;

  assign vin[0] = vec.vec_x;
  assign vin[1] = vec.vec_y;
  assign vin[2] = vec.vec_z;
  assign vin[3] = vec.vec_w;

  // Pass one, t = q*v: sixteen products, signed sums with half an LSB,
  // then rounding and clipping to the wider intermediate format.
  qsr_mul_stage #(.LW(WORD_BITS), .RW(WORD_BITS)) u_mul1 (
    .clk(clk), .rst(rst),
    .up_ctl(in_ctl), .up_ready(mul1_ready), .l_in(quat), .r_in(vin),
    .dn_ctl(mul1_ctl), .dn_ready(sum1_ready), .prod(prod1)
  );

  qsr_sum_stage #(.PW(PW1), .SW(SW1), .FB(FRACTION_BITS),
                  .NEG(qsr_pkg::NEG_Q_TIMES_V)) u_sum1 (
    .clk(clk), .rst(rst),
    .up_ctl(mul1_ctl), .up_ready(sum1_ready), .prod(prod1),
    .dn_ctl(sum1_ctl), .dn_ready(rnd1_ready), .sum(sum1)
  );

  qsr_round_stage #(.SW(SW1), .FB(FRACTION_BITS), .NW(TW)) u_rnd1 (
    .clk(clk), .rst(rst),
    .up_ctl(sum1_ctl), .up_ready(rnd1_ready), .sum(sum1),
    .dn_ctl(rnd1_ctl), .dn_ready(mul2_ready), .res(tq)
  );

  // Pass two, t*conj(q): the conjugate lives in the sign mask, so the
  // multipliers see q itself and no negated copy of q is needed.
  qsr_mul_stage #(.LW(TW), .RW(WORD_BITS)) u_mul2 (
    .clk(clk), .rst(rst),
    .up_ctl(rnd1_ctl), .up_ready(mul2_ready), .l_in(tq), .r_in(quat),
    .dn_ctl(mul2_ctl), .dn_ready(sum2_ready), .prod(prod2)
  );

  qsr_sum_stage #(.PW(PW2), .SW(SW2), .FB(FRACTION_BITS),
                  .NEG(qsr_pkg::NEG_T_TIMES_CONJ)) u_sum2 (
    .clk(clk), .rst(rst),
    .up_ctl(mul2_ctl), .up_ready(sum2_ready), .prod(prod2),
    .dn_ctl(sum2_ctl), .dn_ready(rnd2_ready), .sum(sum2)
  );

  // The last rounding stage is also the output register.
  qsr_round_stage #(.SW(SW2), .FB(FRACTION_BITS), .NW(WORD_BITS)) u_rnd2 (
    .clk(clk), .rst(rst),
    .up_ctl(sum2_ctl), .up_ready(rnd2_ready), .sum(sum2),
    .dn_ctl(rnd2_ctl), .dn_ready(rot.ready), .res(res)
  );

  assign rot.valid     = rnd2_ctl.valid;
  assign rot.saturated = rnd2_ctl.sat;
  assign rot.rot_x     = res[0];
  assign rot.rot_y     = res[1];
  assign rot.rot_z     = res[2];
  assign rot.rot_w     = res[3];

`ifndef SYNTHESIS
  // An empty pipeline always takes a beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !(mul1_ctl.valid || sum1_ctl.valid || rnd1_ctl.valid ||
      mul2_ctl.valid || sum2_ctl.valid || rnd2_ctl.valid) |-> vec.ready)
    else $error("empty pipeline refused an input beat");

  // Input back-pressure only happens when every stage is full and the
  // output is stalled.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !vec.ready |-> (rot.valid && !rot.ready && mul1_ctl.valid && sum1_ctl.valid &&
                    rnd1_ctl.valid && mul2_ctl.valid && sum2_ctl.valid))
    else $error("input stalled while the pipeline had room");

  // A result only appears after its item has passed the second sum stage.
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    (rot.valid && !$past(rot.valid)) |-> $past(sum2_ctl.valid))
    else $error("result beat without a preceding item");

  // A stage that is stalled keeps its item.
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mul2_ctl.valid && !sum2_ready) |=> mul2_ctl.valid)
    else $error("stalled item dropped in the second multiplier stage");
`endif

endmodule

// File: sv/qsr_mul_stage.sv
module qsr_mul_stage #(
  parameter int unsigned LW = 32,
  parameter int unsigned RW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  qsr_pkg::ctl_t             up_ctl,
  output logic                      up_ready,
  input  logic signed [LW-1:0]      l_in [4],
  input  logic signed [RW-1:0]      r_in [4],
  output qsr_pkg::ctl_t             dn_ctl,
  input  logic                      dn_ready,
  output logic signed [LW+RW-1:0]   prod [16]
);

  assign up_ready = !dn_ctl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (up_ready) begin
      dn_ctl.valid <= up_ctl.valid;
    end
    if (up_ready && up_ctl.valid) begin
      dn_ctl.sat <= up_ctl.sat;
      for (int k = 0; k < 16; k++) begin
        prod[k] <= l_in[qsr_pkg::LEFT_IDX[k]] * r_in[qsr_pkg::RIGHT_IDX[k]];
      end
    end
  end

endmodule

// File: sv/qsr_sum_stage.sv
module qsr_sum_stage #(
  parameter int unsigned PW  = 64,
  parameter int unsigned SW  = 67,
  parameter int unsigned FB  = 28,
  parameter logic [15:0] NEG = 16'h0000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qsr_pkg::ctl_t        up_ctl,
  output logic                 up_ready,
  input  logic signed [PW-1:0] prod [16],
  output qsr_pkg::ctl_t        dn_ctl,
  input  logic                 dn_ready,
  output logic signed [SW-1:0] sum [4]
);

  // Half an LSB of the result, added here so the next stage only shifts.
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);

  logic signed [SW-1:0] sum_next [4];

  assign up_ready = !dn_ctl.valid || dn_ready;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_next[c] = HALF;
      for (int j = 0; j < 4; j++) begin
        if (NEG[4*c+j]) begin
          sum_next[c] = sum_next[c] - SW'(prod[4*c+j]);
        end else begin
          sum_next[c] = sum_next[c] + SW'(prod[4*c+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (up_ready) begin
      dn_ctl.valid <= up_ctl.valid;
    end
    if (up_ready && up_ctl.valid) begin
      dn_ctl.sat <= up_ctl.sat;
      sum        <= sum_next;
    end
  end

endmodule

// File: sv/qsr_round_stage.sv
module qsr_round_stage #(
  parameter int unsigned SW = 67,
  parameter int unsigned FB = 28,
  parameter int unsigned NW = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qsr_pkg::ctl_t        up_ctl,
  output logic                 up_ready,
  input  logic signed [SW-1:0] sum [4],
  output qsr_pkg::ctl_t        dn_ctl,
  input  logic                 dn_ready,
  output logic signed [NW-1:0] res [4]
);

  localparam int unsigned HW = SW - FB;
  localparam logic signed [NW-1:0] MAX_VAL = {1'b0, {(NW-1){1'b1}}};
  localparam logic signed [NW-1:0] MIN_VAL = {1'b1, {(NW-1){1'b0}}};

  logic [HW-1:0]        shifted  [4];
  logic [3:0]           over;
  logic signed [NW-1:0] res_next [4];

  assign up_ready = !dn_ctl.valid || dn_ready;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      shifted[c] = sum[c][SW-1:FB];
      // In range when every bit above the result's sign bit matches it.
      over[c] = !((&shifted[c][HW-1:NW-1]) || !(|shifted[c][HW-1:NW-1]));
      if (over[c]) begin
        res_next[c] = shifted[c][HW-1] ? MIN_VAL : MAX_VAL;
      end else begin
        res_next[c] = shifted[c][NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (up_ready) begin
      dn_ctl.valid <= up_ctl.valid;
    end
    if (up_ready && up_ctl.valid) begin
      dn_ctl.sat <= up_ctl.sat || (|over);
      res        <= res_next;
    end
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;

  // The block is built at its default widths: Q4.28 in 32-bit words, with
  // four guard bits on the intermediate product q*v.
  localparam int unsigned WORD_BITS = qsr_pkg::WORD_BITS_DEF;
  localparam int unsigned FRAC_BITS = qsr_pkg::FRACTION_BITS_DEF;

  // Run shape. The limit is far above the slowest legal run, which is about
  // 1250 beats, each with a full sender gap and a full receiver stall.
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 123;
  localparam int unsigned LONG_HOLD       = 60;
  localparam int unsigned LIMIT_CYCLES    = 500000;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [127:0]         wide_t;
  typedef logic [3:0][127:0]           wide_quad_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } quad_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  sat;
  } rotated_t;

  // One Hamilton product, each component already rounded and clipped.
  typedef struct packed {
    wide_quad_t part;
    logic       clipped;
  } product_t;

  // A directed row: the quaternion it needs, the beat to send, and, where it
  // can be worked out by hand, the result that must come back.
  typedef struct packed {
    quad_t    quat;
    quad_t    vec;
    logic     typed;
    rotated_t want;
  } row_t;

  localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC_BITS - 1);

  localparam word_t ZERO      = 32'sh0000_0000;
  localparam word_t LSB       = 32'sh0000_0001;
  localparam word_t NEG_LSB   = 32'shFFFF_FFFF;
  localparam word_t HALF      = 32'sh0800_0000;
  localparam word_t ONE       = 32'sh1000_0000;
  localparam word_t NEG_ONE   = 32'shF000_0000;
  localparam word_t TWO       = 32'sh2000_0000;
  localparam word_t NEG_TWO   = 32'shE000_0000;
  localparam word_t FOUR      = 32'sh4000_0000;
  localparam word_t WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN  = 32'sh8000_0000;
  // cos(45 degrees) in Q4.28, so Q_TURN_Z is a quarter turn about k.
  localparam word_t ROOT_HALF = 32'sh0B50_4F33;

  localparam quad_t Q_IDENT  = {ZERO, ZERO, ZERO, ONE};
  localparam quad_t Q_FLIP   = {ZERO, ZERO, ZERO, NEG_ONE};
  localparam quad_t Q_DOUBLE = {ZERO, ZERO, ZERO, TWO};
  localparam quad_t Q_HALF   = {ZERO, ZERO, ZERO, HALF};
  localparam quad_t Q_TURN_Z = {ZERO, ZERO, ROOT_HALF, ROOT_HALF};
  localparam quad_t Q_MAX    = {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
  localparam quad_t Q_MIN    = {WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
  localparam quad_t Q_MIXED  = {32'sh3A5C_0F11, 32'shC1D2_E3F4, LSB, NEG_LSB};

  localparam rotated_t UNTYPED = '0;

  localparam int unsigned DIRECTED_ROWS = 20;

  // The identity and its negation must hand every beat back unchanged, the
  // extremes included. Scaling by two (q = 2.0 gives a factor of four) shows
  // the final clip: 2.0 goes to 8.0 and clips, -2.0 lands exactly on the
  // most negative word and does not. Scaling by one half walks the rounding
  // ties, and the all-min quaternion overflows the intermediate.
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    {Q_IDENT, {ZERO, ZERO, ZERO, ZERO}, 1'b1, {ZERO, ZERO, ZERO, ZERO, 1'b0}},
    {Q_IDENT, {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}, 1'b1,
     {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0}},
    {Q_IDENT, {WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}, 1'b1,
     {WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0}},
    {Q_IDENT, {LSB, NEG_LSB, ONE, NEG_ONE}, 1'b1, {LSB, NEG_LSB, ONE, NEG_ONE, 1'b0}},
    {Q_IDENT, {32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC}, 1'b1,
     {32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC, 1'b0}},
    {Q_FLIP, {WORD_MIN, 32'sh8765_4321, 32'sh0F0F_0F0F, 32'shF0F0_F0F0}, 1'b1,
     {WORD_MIN, 32'sh8765_4321, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 1'b0}},
    {Q_DOUBLE, {ONE, ZERO, ZERO, ZERO}, 1'b1, {FOUR, ZERO, ZERO, ZERO, 1'b0}},
    {Q_DOUBLE, {TWO, ZERO, ZERO, ZERO}, 1'b1, {WORD_MAX, ZERO, ZERO, ZERO, 1'b1}},
    {Q_DOUBLE, {NEG_TWO, ZERO, ZERO, ZERO}, 1'b1, {WORD_MIN, ZERO, ZERO, ZERO, 1'b0}},
    {Q_DOUBLE, {ZERO, ZERO, ZERO, TWO}, 1'b1, {ZERO, ZERO, ZERO, WORD_MAX, 1'b1}},
    {Q_HALF, {LSB, NEG_LSB, 32'sh0000_0003, 32'shFFFF_FFFD}, 1'b0, UNTYPED},
    {Q_HALF, {WORD_MAX, WORD_MIN, HALF, NEG_ONE}, 1'b0, UNTYPED},
    {Q_TURN_Z, {ONE, ZERO, ZERO, ZERO}, 1'b0, UNTYPED},
    {Q_TURN_Z, {ZERO, ONE, NEG_ONE, ZERO}, 1'b0, UNTYPED},
    {Q_MAX, {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}, 1'b0, UNTYPED},
    {Q_MAX, {WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}, 1'b0, UNTYPED},
    {Q_MIN, {WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}, 1'b0, UNTYPED},
    {Q_MIN, {WORD_MAX, ZERO, WORD_MIN, LSB}, 1'b0, UNTYPED},
    {Q_MIXED, {LSB, NEG_LSB, FOUR, NEG_TWO}, 1'b0, UNTYPED},
    {Q_MIXED, {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}, 1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst;
  logic                               cfg_we;
  logic [qsr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]               cfg_wdata;

  qsr_vec_if #(.WORD_BITS(WORD_BITS)) vec_bus ();
  qsr_rot_if #(.WORD_BITS(WORD_BITS)) rot_bus ();

  quaternion_sandwich_rotation_core #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .vec       (vec_bus),
    .rot       (rot_bus)
  );

  always #1 clk = ~clk;

  // Our own copy of the quaternion registers, and the rotations still owed
  // by the block, oldest first.
  quad_t       quat_now;
  rotated_t    expected_rotations [$];
  bit          idling_on;
  bit          hold_rot;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned saturated_seen;
  int unsigned quat_loads;

  // Hamilton product l*r. The four products of a component are summed at
  // full precision, rounded once (half an LSB added, then an arithmetic
  // shift, so ties go upwards) and clipped to keep_bits signed bits.
  function automatic product_t hamilton(wide_quad_t l, wide_quad_t r,
                                        int unsigned keep_bits);
    wide_t    lx, ly, lz, lw, rx, ry, rz, rw, top, s;
    wide_t    sums [4];
    product_t res;
    lx = l[0]; ly = l[1]; lz = l[2]; lw = l[3];
    rx = r[0]; ry = r[1]; rz = r[2]; rw = r[3];
    sums[0] = ly * rz - lz * ry + rw * lx + lw * rx;
    sums[1] = lz * rx - lx * rz + rw * ly + lw * ry;
    sums[2] = lx * ry - ly * rx + rw * lz + lw * rz;
    sums[3] = lw * rw - lx * rx - ly * ry - lz * rz;
    top = wide_t'(1) <<< (keep_bits - 1);
    res.clipped = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s = (sums[i] + HALF_LSB) >>> FRAC_BITS;
      if (s >= top) begin
        s = top - 1;
        res.clipped = 1'b1;
      end else if (s < -top) begin
        s = -top;
        res.clipped = 1'b1;
      end
      res.part[i] = s;
    end
    return res;
  endfunction

  // q*v*conj(q) under the quaternion currently loaded. The intermediate is
  // kept with four guard bits; a clip in either pass raises sat.
  function automatic rotated_t rotate_item(quad_t v);
    wide_quad_t q, qc, vw;
    product_t   t, r;
    rotated_t   res;
    q[0] = wide_t'($signed(quat_now.x));
    q[1] = wide_t'($signed(quat_now.y));
    q[2] = wide_t'($signed(quat_now.z));
    q[3] = wide_t'($signed(quat_now.w));
    qc[0] = -$signed(q[0]);
    qc[1] = -$signed(q[1]);
    qc[2] = -$signed(q[2]);
    qc[3] = q[3];
    vw[0] = wide_t'($signed(v.x));
    vw[1] = wide_t'($signed(v.y));
    vw[2] = wide_t'($signed(v.z));
    vw[3] = wide_t'($signed(v.w));
    t = hamilton(q, vw, WORD_BITS + qsr_pkg::GUARD_BITS);
    r = hamilton(t.part, qc, WORD_BITS);
    res.x = r.part[0][WORD_BITS-1:0];
    res.y = r.part[1][WORD_BITS-1:0];
    res.z = r.part[2][WORD_BITS-1:0];
    res.w = r.part[3][WORD_BITS-1:0];
    res.sat = t.clipped | r.clipped;
    return res;
  endfunction

  // Half the random beats are plain 3-vectors within about four units, as a
  // mesh would send them; the rest are general four-component items, full
  // range words, and the corner values mixed at random.
  function automatic quad_t random_item();
    word_t       c [4];
    word_t       corners [7];
    int unsigned pick;
    corners = '{ZERO, WORD_MAX, WORD_MIN, LSB, NEG_LSB, ONE, NEG_ONE};
    pick = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (pick < 5)
        c[i] = (i == 3) ? ZERO : word_t'($urandom) >>> 1;
      else if (pick < 7)
        c[i] = word_t'($urandom) >>> 1;
      else if (pick < 9)
        c[i] = word_t'($urandom);
      else
        c[i] = corners[$urandom_range(0, 6)];
    end
    return {c[0], c[1], c[2], c[3]};
  endfunction

  // A unit quaternion about a random axis through a random angle, which is
  // what a real rotation would load.
  function automatic quad_t random_turn();
    real ax, ay, az, norm, half_angle, s, scale;
    scale = real'(ONE);
    ax = real'(int'($urandom_range(0, 2000)) - 1000);
    ay = real'(int'($urandom_range(0, 2000)) - 1000);
    az = real'(int'($urandom_range(0, 2000)) - 1000);
    norm = $sqrt(ax * ax + ay * ay + az * az);
    if (norm == 0.0) begin
      az = 1.0;
      norm = 1.0;
    end
    half_angle = real'($urandom_range(0, 31416)) / 10000.0;
    s = $sin(half_angle) * scale;
    return {word_t'($rtoi(ax / norm * s)), word_t'($rtoi(ay / norm * s)),
            word_t'($rtoi(az / norm * s)), word_t'($rtoi($cos(half_angle) * scale))};
  endfunction

  // Offers one beat and holds it until the block takes it. A random gap may
  // come first, except while the receiver is holding off on purpose, when
  // the input must be kept full.
  task automatic offer(quad_t v, logic typed, rotated_t want);
    if (idling_on && !hold_rot && $urandom_range(0, 5) == 0) begin
      vec_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    vec_bus.valid <= 1'b1;
    vec_bus.vec_x <= v.x;
    vec_bus.vec_y <= v.y;
    vec_bus.vec_z <= v.z;
    vec_bus.vec_w <= v.w;
    do @(posedge clk); while (!vec_bus.ready);
    expected_rotations.push_back(typed ? want : rotate_item(v));
  endtask

  // Stops sending and waits until every owed rotation has come back, so the
  // pipeline is empty before the quaternion changes.
  task automatic settle();
    vec_bus.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_quat(quad_t q);
    word_t                              vals [4];
    logic [qsr_pkg::CFG_INDEX_BITS-1:0] regs [4];
    vals = '{q.x, q.y, q.z, q.w};
    regs = '{qsr_pkg::REG_QUAT_X, qsr_pkg::REG_QUAT_Y,
             qsr_pkg::REG_QUAT_Z, qsr_pkg::REG_QUAT_W};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    quat_now = q;
    quat_loads++;
  endtask

  task automatic compare_field(string field, word_t want, word_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Every result beat is matched against the oldest rotation still owed.
  always @(posedge clk) begin : result_check
    rotated_t want;
    if (!rst && rot_bus.valid && rot_bus.ready) begin
      if (expected_rotations.size() == 0) begin
        $error("result beat with nothing expected: rot_x %0d", rot_bus.rot_x);
        mismatches++;
      end else begin
        want = expected_rotations.pop_front();
        compare_field("rot_x", want.x, rot_bus.rot_x);
        compare_field("rot_y", want.y, rot_bus.rot_y);
        compare_field("rot_z", want.z, rot_bus.rot_z);
        compare_field("rot_w", want.w, rot_bus.rot_w);
        if (rot_bus.saturated !== want.sat) begin
          $error("saturated mismatch: expected %0b, got %0b", want.sat,
                 rot_bus.saturated);
          mismatches++;
        end
        results_checked++;
        if (want.sat)
          saturated_seen++;
      end
    end
  end

  // The receiver alternates bursts of readiness with random stalls. When asked,
  // it holds off for a long stretch so that the pipeline fills and the block
  // has to stall its input.
  initial begin : rot_receiver
    rot_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rot) begin
        rot_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rot = 1'b0;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        rot_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        rot_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    quad_t q;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= qsr_pkg::REG_QUAT_X;
    cfg_wdata     <= '0;
    vec_bus.valid <= 1'b0;
    vec_bus.vec_x <= '0;
    vec_bus.vec_y <= '0;
    vec_bus.vec_z <= '0;
    vec_bus.vec_w <= '0;
    quat_now        = Q_IDENT;
    idling_on       = 1'b1;
    hold_rot        = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    saturated_seen  = 0;
    quat_loads      = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. The first ones run on the quaternion left by reset; a
    // new quaternion is loaded only once the previous rows have drained.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].quat != quat_now) begin
        settle();
        load_quat(DIRECTED[i].quat);
      end
      offer(DIRECTED[i].vec, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases, one quaternion each: four true rotations, plus the
    // identity, the register extremes, zero, small and full-range values.
    // Some phases run without idling, the last one among them.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       q = Q_IDENT;
        2:       q = Q_MAX;
        3:       q = Q_MIN;
        4:       q = '0;
        6:       q = {word_t'($urandom) >>> 3, word_t'($urandom) >>> 3,
                      word_t'($urandom) >>> 3, word_t'($urandom) >>> 3};
        7:       q = {word_t'($urandom), word_t'($urandom),
                      word_t'($urandom), word_t'($urandom)};
        default: q = random_turn();
      endcase
      settle();
      load_quat(q);
      idling_on = (p % 4 != 3) && (p != PHASES - 1);
      // The first phase starts with the receiver holding off while beats
      // keep being offered.
      if (p == 0)
        hold_rot = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        offer(random_item(), 1'b0, UNTYPED);
    end

    settle();
    // Allow for any stray beat the block might still put out.
    repeat (12) @(posedge clk);
    $display("Rotated %0d beats under %0d quaternion settings; %0d came back saturated.",
             results_checked, quat_loads + 1, saturated_seen);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

endmodule
